// ===== rtl/twlh_pkg.sv =====
// Package of shared types, constants and functions for the word tokenizer and line hasher.
package twlh_pkg;

  localparam logic [15:0] MAX_LINE_BYTES = 16'd65535;
  localparam logic [15:0] MAX_LINES      = 16'd65535;
  localparam int unsigned HASH_ROT       = 7;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned MAX_RECS       = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FOLD_CASE   = 2'd0,
    CFG_SKIP_SPACES = 2'd1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CLS_SPACE = 2'd0,
    CLS_WORD  = 2'd1,
    CLS_OTHER = 2'd2
  } cls_t;

  typedef enum logic {
    KIND_WORD = 1'b0,
    KIND_LINE = 1'b1
  } kind_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       line_empty;
    logic       line_end;
  } item_t;

  typedef struct packed {
    kind_t       kind;
    cls_t        cls;
    logic [15:0] line;
    logic [15:0] start;
    logic [15:0] len;
    logic [31:0] hash;
    logic        last;
  } rec_t;

  // Records produced by one transaction, slot 0 delivered first
  typedef struct packed {
    logic [1:0]                n;
    rec_t [MAX_RECS-1:0]       rec;
  } batch_t;

  function automatic logic [31:0] mix(input logic [31:0] h, input logic [7:0] c);
    logic [31:0] rot;
    rot = {h[31-HASH_ROT:0], h[31:32-HASH_ROT]};
    return rot + {{24{c[7]}}, c};
  endfunction

  function automatic cls_t class_of(input logic [7:0] c);
    cls_t r;
    if (c == 8'h20 || c == 8'h09) begin
      r = CLS_SPACE;
    end else if ((c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
                 (c >= 8'h30 && c <= 8'h39) || c == 8'h5f) begin
      r = CLS_WORD;
    end else begin
      r = CLS_OTHER;
    end
    return r;
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] v, input logic [15:0] max);
    return (v >= max) ? max : v + 16'd1;
  endfunction

endpackage

// ===== rtl/twlh_in_if.sv =====
// Input channel interface: one text byte per transaction with line flags.
interface twlh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       line_empty;
  logic       line_end;

  modport source (output valid, char_byte, line_empty, line_end, input ready);
  modport sink   (input valid, char_byte, line_empty, line_end, output ready);
endinterface

// ===== rtl/twlh_out_if.sv =====
// Result channel interface: one word or line record per transaction.
interface twlh_out_if;
  logic        valid;
  logic        ready;
  logic        record_kind;
  logic [1:0]  word_class;
  logic [15:0] line_index;
  logic [15:0] start_pos;
  logic [15:0] word_length;
  logic [31:0] hash_value;
  logic        last_of_run;

  modport source (output valid, record_kind, word_class, line_index, start_pos,
                  word_length, hash_value, last_of_run, input ready);
  modport sink   (input valid, record_kind, word_class, line_index, start_pos,
                  word_length, hash_value, last_of_run, output ready);
endinterface

// ===== rtl/twlh_cfg_if.sv =====
// Configuration write channel interface: register index and write data.
interface twlh_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [twlh_pkg::CFG_IDX_W-1:0]      index;
  logic                                data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/twlh_core.sv =====
// Tokenizer core: classes each byte, tracks the open word and line, builds the records.
module twlh_core (
  input  logic                 clk,
  input  logic                 rst_n,
  twlh_cfg_if.sink             cfg_ch,
  input  logic                 accept,
  input  twlh_pkg::item_t      item,
  output twlh_pkg::batch_t     batch
);

  logic                 fold_case_r;
  logic                 skip_spaces_r;
  twlh_pkg::cls_t       run_class_r;
  logic [31:0]          run_hash_r;
  logic [15:0]          run_start_r;
  logic [15:0]          run_len_r;
  logic                 run_open_r;
  logic [15:0]          byte_pos_r;
  logic [15:0]          line_cnt_r;
  logic [31:0]          line_hash_r;

  logic [7:0]           c;
  twlh_pkg::cls_t       cls;
  logic                 new_run;
  logic [31:0]          run_hash_nxt;
  logic [15:0]          run_start_nxt;
  logic [15:0]          run_len_nxt;
  logic [31:0]          line_hash_upd;
  logic [15:0]          line_cnt_nxt;
  twlh_pkg::rec_t [2:0] cand;
  logic [2:0]           cand_v;
  logic [1:0]           slot;

  // Take configuration writes at any time
  assign cfg_ch.ready = 1'b1;

  // Fold case, class the byte and advance the open word
  always_comb begin
    c = item.char_byte;
    if (fold_case_r && c >= 8'h41 && c <= 8'h5a) begin
      c = c + 8'd32;
    end
    cls           = twlh_pkg::class_of(c);
    new_run       = !run_open_r || (cls != run_class_r);
    run_hash_nxt  = twlh_pkg::mix(new_run ? 32'd0 : run_hash_r, c);
    run_start_nxt = new_run ? byte_pos_r : run_start_r;
    run_len_nxt   = new_run ? 16'd1 : twlh_pkg::sat_inc(run_len_r, twlh_pkg::MAX_LINE_BYTES);
    line_hash_upd = (skip_spaces_r && cls == twlh_pkg::CLS_SPACE) ? line_hash_r
                                                                 : twlh_pkg::mix(line_hash_r, c);
    line_cnt_nxt  = twlh_pkg::sat_inc(line_cnt_r, twlh_pkg::MAX_LINES);
  end

  // Build candidate records: old word, word closed by line end, line record
  always_comb begin
    cand_v[0] = run_open_r && (item.line_empty || cls != run_class_r) &&
                !(skip_spaces_r && run_class_r == twlh_pkg::CLS_SPACE);
    cand_v[1] = !item.line_empty && item.line_end &&
                !(skip_spaces_r && cls == twlh_pkg::CLS_SPACE);
    cand_v[2] = item.line_empty || item.line_end;

    cand[0] = '{kind: twlh_pkg::KIND_WORD, cls: run_class_r, line: line_cnt_r,
                start: run_start_r, len: run_len_r, hash: run_hash_r, last: 1'b0};
    cand[1] = '{kind: twlh_pkg::KIND_WORD, cls: cls, line: line_cnt_r,
                start: run_start_nxt, len: run_len_nxt, hash: run_hash_nxt, last: 1'b0};
    cand[2] = '{kind: twlh_pkg::KIND_LINE, cls: twlh_pkg::CLS_SPACE, line: line_cnt_r,
                start: 16'd0, len: 16'd0,
                hash: item.line_empty ? line_hash_r : line_hash_upd, last: 1'b0};
  end

  // Pack valid candidates in order and flag the final one
  always_comb begin
    batch = '0;
    slot  = 2'd0;
    for (int i = 0; i < 3; i++) begin
      if (cand_v[i]) begin
        batch.rec[slot] = cand[i];
        slot = slot + 2'd1;
      end
    end
    batch.n = slot;
    for (int i = 0; i < 3; i++) begin
      batch.rec[i].last = (2'(i) == slot - 2'd1);
    end
  end

  // Hold configuration and tokenizer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fold_case_r   <= 1'b0;
      skip_spaces_r <= 1'b0;
      run_class_r   <= twlh_pkg::CLS_SPACE;
      run_hash_r    <= 32'd0;
      run_start_r   <= 16'd0;
      run_len_r     <= 16'd0;
      run_open_r    <= 1'b0;
      byte_pos_r    <= 16'd0;
      line_cnt_r    <= 16'd0;
      line_hash_r   <= 32'd0;
    end else begin
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          twlh_pkg::CFG_FOLD_CASE:   fold_case_r   <= cfg_ch.data;
          twlh_pkg::CFG_SKIP_SPACES: skip_spaces_r <= cfg_ch.data;
          default: ;
        endcase
      end
      if (accept) begin
        if (item.line_empty) begin
          run_open_r  <= 1'b0;
          line_hash_r <= 32'd0;
          byte_pos_r  <= 16'd0;
          line_cnt_r  <= line_cnt_nxt;
        end else begin
          run_class_r <= cls;
          run_hash_r  <= run_hash_nxt;
          run_start_r <= run_start_nxt;
          run_len_r   <= run_len_nxt;
          run_open_r  <= !item.line_end;
          line_hash_r <= item.line_end ? 32'd0 : line_hash_upd;
          byte_pos_r  <= item.line_end ? 16'd0
                         : twlh_pkg::sat_inc(byte_pos_r, twlh_pkg::MAX_LINE_BYTES);
          if (item.line_end) begin
            line_cnt_r <= line_cnt_nxt;
          end
        end
      end
    end
  end

  // An open word never starts past the current byte position
  a_start_le_pos: assert property (@(posedge clk) disable iff (!rst_n)
    run_open_r |-> run_start_r <= byte_pos_r)
    else $error("open word starts beyond byte position");

  // A line close always yields at least the line record
  a_line_has_rec: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (item.line_empty || item.line_end)) |-> batch.n != 2'd0)
    else $error("line close produced no record");

endmodule

// ===== rtl/twlh_outq.sv =====
// Result queue: holds up to three records of one transaction and drains them in order.
module twlh_outq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  twlh_pkg::batch_t     batch,
  output logic                 can_load,
  twlh_out_if.source           out_ch
);

  twlh_pkg::rec_t [2:0] q_r;
  logic [1:0]           count_r;
  logic                 pop;

  assign pop      = (count_r != 2'd0) && out_ch.ready;
  assign can_load = (count_r == 2'd0) || ((count_r == 2'd1) && out_ch.ready);

  // Drive the head record
  assign out_ch.valid       = (count_r != 2'd0);
  assign out_ch.record_kind = q_r[0].kind;
  assign out_ch.word_class  = q_r[0].cls;
  assign out_ch.line_index  = q_r[0].line;
  assign out_ch.start_pos   = q_r[0].start;
  assign out_ch.word_length = q_r[0].len;
  assign out_ch.hash_value  = q_r[0].hash;
  assign out_ch.last_of_run = q_r[0].last;

  // Track fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else if (load) begin
      count_r <= batch.n;
    end else if (pop) begin
      count_r <= count_r - 2'd1;
    end
  end

  // Load a new batch or shift toward the head
  always_ff @(posedge clk) begin
    if (load) begin
      q_r <= batch.rec;
    end else if (pop) begin
      q_r[0] <= q_r[1];
      q_r[1] <= q_r[2];
    end
  end

  // A batch loads only once the queue drains
  a_load_empty: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (count_r == 2'd0 || (count_r == 2'd1 && pop)))
    else $error("batch loaded over pending records");

  // The single remaining record is the final one of its batch
  a_tail_last: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd1) |-> q_r[0].last)
    else $error("lone record not marked final");

endmodule

// ===== rtl/text_word_tokenizer_line_hasher.sv =====
// Top level of the text word tokenizer and line hasher.
// The first record of a transaction is on out_ch in the cycle after acceptance.
// Throughput: one byte per cycle while each byte yields at most one record and out_ch is ready;
//   a transaction yielding k records (k up to 3) holds off new bytes until its last record is leaving.
// Reset: synchronous active-low rst_n clears configuration, word, line state and the queue.
module text_word_tokenizer_line_hasher (
  input  logic        clk,
  input  logic        rst_n,
  twlh_in_if.sink     in_ch,
  twlh_out_if.source  out_ch,
  twlh_cfg_if.sink    cfg_ch
);

  twlh_pkg::item_t  item;
  twlh_pkg::batch_t batch;
  logic             can_load;
  logic             accept;

  // Accept a byte whenever the queue will be free next cycle
  assign in_ch.ready = can_load;
  assign accept      = in_ch.valid && can_load;
  assign item        = '{char_byte: in_ch.char_byte, line_empty: in_ch.line_empty,
                         line_end: in_ch.line_end};

  twlh_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .accept (accept),
    .item   (item),
    .batch  (batch)
  );

  twlh_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (accept),
    .batch    (batch),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

endmodule

// ===== tb/twlh_token_checker.sv =====
// Checker for the word tokenizer and line hasher: predicts records and compares them.
module twlh_token_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [7:0]                     in_char,
  input  logic                           in_empty,
  input  logic                           in_end,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic                           out_kind,
  input  logic [1:0]                     out_class,
  input  logic [15:0]                    out_line,
  input  logic [15:0]                    out_start,
  input  logic [15:0]                    out_length,
  input  logic [31:0]                    out_hash,
  input  logic                           out_last,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [twlh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic                           cfg_data,
  output int                             fail_count,
  output int                             pending_count,
  output int                             records_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  // Register copies
  logic              fold_on;
  logic              skip_on;

  // Open word and line state
  twlh_pkg::cls_t    word_cls;
  logic [31:0]       word_hash;
  logic [15:0]       word_start;
  logic [15:0]       word_len;
  logic              word_open;
  logic [15:0]       line_pos;
  logic [15:0]       line_no;
  logic [31:0]       line_hash;

  // Records still owed by the block, oldest first
  twlh_pkg::rec_t    due_records[$];
  // Records caused by the byte being tokenized
  twlh_pkg::rec_t    step_recs[$];

  function automatic logic [31:0] rotadd(input logic [31:0] acc, input logic [7:0] b);
    return {acc[24:0], acc[31:25]} + {{24{b[7]}}, b};
  endfunction

  function automatic twlh_pkg::cls_t char_group(input logic [7:0] b);
    if (b == " " || b == 8'h09) return twlh_pkg::CLS_SPACE;
    if ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
        (b >= "0" && b <= "9") || b == "_") return twlh_pkg::CLS_WORD;
    return twlh_pkg::CLS_OTHER;
  endfunction

  function automatic logic [15:0] sat_up(input logic [15:0] v, input logic [15:0] top);
    return (v >= top) ? top : v + 16'd1;
  endfunction

  function automatic void add_record(input twlh_pkg::kind_t k, input twlh_pkg::cls_t c,
                                     input logic [15:0] st, input logic [15:0] ln,
                                     input logic [31:0] h);
    twlh_pkg::rec_t r;
    r.kind  = k;
    r.cls   = c;
    r.line  = line_no;
    r.start = st;
    r.len   = ln;
    r.hash  = h;
    r.last  = 1'b0;
    step_recs = {step_recs, r};
  endfunction

  // Emit the open word unless it is a dropped space word
  function automatic void close_word();
    if (word_open) begin
      if (!(skip_on && word_cls == twlh_pkg::CLS_SPACE))
        add_record(twlh_pkg::KIND_WORD, word_cls, word_start, word_len, word_hash);
      word_open = 1'b0;
    end
  endfunction

  function automatic void close_line();
    close_word();
    add_record(twlh_pkg::KIND_LINE, twlh_pkg::CLS_SPACE, 16'd0, 16'd0, line_hash);
    line_hash = '0;
    line_pos  = '0;
    line_no   = sat_up(line_no, twlh_pkg::MAX_LINES);
  endfunction

  function automatic void tokenize_byte(input logic [7:0] b, input logic empty, input logic eol);
    logic [7:0]     c;
    twlh_pkg::cls_t g;
    twlh_pkg::rec_t r;
    step_recs.delete();
    if (empty) begin
      close_line();
    end else begin
      c = b;
      if (fold_on && c >= "A" && c <= "Z") c = c + 8'd32;
      g = char_group(c);
      if (word_open && g != word_cls) close_word();
      if (!word_open) begin
        word_cls   = g;
        word_hash  = rotadd(32'd0, c);
        word_start = line_pos;
        word_len   = 16'd1;
        word_open  = 1'b1;
      end else begin
        word_hash = rotadd(word_hash, c);
        word_len  = sat_up(word_len, twlh_pkg::MAX_LINE_BYTES);
      end
      if (!(skip_on && g == twlh_pkg::CLS_SPACE)) line_hash = rotadd(line_hash, c);
      line_pos = sat_up(line_pos, twlh_pkg::MAX_LINE_BYTES);
      if (eol) close_line();
    end
    // Flag the final record of this transaction
    foreach (step_recs[i]) begin
      r = step_recs[i];
      r.last = (i == step_recs.size() - 1);
      due_records = {due_records, r};
    end
  endfunction

  function automatic bit records_differ(input twlh_pkg::rec_t want, input twlh_pkg::rec_t got);
    return (want.kind !== got.kind) || (want.cls !== got.cls) || (want.line !== got.line) ||
           (want.start !== got.start) || (want.len !== got.len) ||
           (want.hash !== got.hash) || (want.last !== got.last);
  endfunction

  function automatic void report_failure(input string what, input twlh_pkg::rec_t want,
                                         input twlh_pkg::rec_t got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t %s: expected kind=%0d class=%0d line=%0d start=%0d len=%0d hash=%h last=%0d",
               $time, what, want.kind, want.cls, want.line, want.start, want.len, want.hash,
               want.last);
      $display("%0t %s:   actual kind=%0d class=%0d line=%0d start=%0d len=%0d hash=%h last=%0d",
               $time, what, got.kind, got.cls, got.line, got.start, got.len, got.hash,
               got.last);
    end
  endfunction

  always @(posedge clk) begin : track
    twlh_pkg::rec_t got;
    twlh_pkg::rec_t want;
    if (!rst_n) begin
      fold_on         = 1'b0;
      skip_on         = 1'b0;
      word_cls        = twlh_pkg::CLS_SPACE;
      word_hash       = '0;
      word_start      = '0;
      word_len        = '0;
      word_open       = 1'b0;
      line_pos        = '0;
      line_no         = '0;
      line_hash       = '0;
      fail_count      = 0;
      records_checked = 0;
      due_records.delete();
    end else begin
      // Compare a delivered record with the oldest one owed
      if (out_valid && out_ready) begin
        got.kind  = twlh_pkg::kind_t'(out_kind);
        got.cls   = twlh_pkg::cls_t'(out_class);
        got.line  = out_line;
        got.start = out_start;
        got.len   = out_length;
        got.hash  = out_hash;
        got.last  = out_last;
        records_checked++;
        if (due_records.size() == 0) begin
          report_failure("unexpected record", '0, got);
        end else begin
          want = due_records.pop_front();
          if (records_differ(want, got)) report_failure("record mismatch", want, got);
        end
      end
      // Predict the records of an accepted byte with the registers it saw
      if (in_valid && in_ready) tokenize_byte(in_char, in_empty, in_end);
      // Track register writes
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == twlh_pkg::CFG_FOLD_CASE) fold_on = cfg_data;
        else if (cfg_index == twlh_pkg::CFG_SKIP_SPACES) skip_on = cfg_data;
      end
    end
    pending_count <= due_records.size();
  end

endmodule

// ===== tb/text_word_tokenizer_line_hasher_test.sv =====
// Top of the tokenizer testbench: clock, reset, stimulus, result drain and verdict.
module text_word_tokenizer_line_hasher_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES   = 8;
  localparam int HOLD_CYCLES     = 150;
  localparam int PHASE_ITEMS     = 14;
  // Register settings of the random phases, bit p for phase p
  localparam bit [4:0] FOLD_PLAN = 5'b10101;
  localparam bit [4:0] SKIP_PLAN = 5'b10110;

  logic clk;
  logic rst_n;
  logic hold_off_req;
  int   burst_left;
  int   items_sent;
  int   fail_count;
  int   pending_count;
  int   records_checked;

  twlh_in_if  in_ch();
  twlh_out_if out_ch();
  twlh_cfg_if cfg_ch();

  text_word_tokenizer_line_hasher i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  twlh_token_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_char         (in_ch.char_byte),
    .in_empty        (in_ch.line_empty),
    .in_end          (in_ch.line_end),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_kind        (out_ch.record_kind),
    .out_class       (out_ch.word_class),
    .out_line        (out_ch.line_index),
    .out_start       (out_ch.start_pos),
    .out_length      (out_ch.word_length),
    .out_hash        (out_ch.hash_value),
    .out_last        (out_ch.last_of_run),
    .cfg_valid       (cfg_ch.valid),
    .cfg_ready       (cfg_ch.ready),
    .cfg_index       (cfg_ch.index),
    .cfg_data        (cfg_ch.data),
    .fail_count      (fail_count),
    .pending_count   (pending_count),
    .records_checked (records_checked)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Offer one byte transaction, opening a random gap between bursts
  task automatic offer_item(input logic [7:0] b, input logic empty, input logic eol,
                            input bit gapless);
    int gap;
    if (!gapless && burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    in_ch.valid      <= 1'b1;
    in_ch.char_byte  <= b;
    in_ch.line_empty <= empty;
    in_ch.line_end   <= eol;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // Hold the sender until every owed record has arrived and the block is quiet
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input twlh_pkg::cfg_idx_t idx, input logic d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte(input twlh_pkg::cls_t g);
    case (g)
      twlh_pkg::CLS_SPACE: return $urandom_range(0, 1) ? 8'h20 : 8'h09;
      twlh_pkg::CLS_WORD: begin
        case ($urandom_range(0, 3))
          0:       return 8'($urandom_range(97, 122));
          1:       return 8'($urandom_range(65, 90));
          2:       return 8'($urandom_range(48, 57));
          default: return "_";
        endcase
      end
      default: begin
        case ($urandom_range(0, 6))
          0:       return 8'($urandom_range(0, 8));
          1:       return 8'($urandom_range(10, 31));
          2:       return 8'($urandom_range(33, 47));
          3:       return 8'($urandom_range(58, 64));
          4:       return 8'($urandom_range(91, 94));
          5:       return $urandom_range(0, 1) ? 8'h60 : 8'($urandom_range(123, 127));
          default: return 8'($urandom_range(128, 255));
        endcase
      end
    endcase
  endfunction

  // Mostly well-formed lines of random runs, with junk empty-line and stray bytes
  task automatic random_text(input int quota, input bit gapless);
    int             sent;
    int             runs;
    int             run_len;
    twlh_pkg::cls_t g;
    sent = 0;
    while (sent < quota) begin
      case ($urandom_range(0, 19))
        0, 1: begin
          offer_item(8'($urandom), 1'b1, 1'($urandom), gapless);
          sent++;
        end
        2, 3, 4: begin
          offer_item(8'($urandom), 1'b0, ($urandom_range(0, 3) == 0), gapless);
          sent++;
        end
        default: begin
          runs = $urandom_range(1, 4);
          for (int r = 0; r < runs; r++) begin
            g = twlh_pkg::cls_t'($urandom_range(0, 2));
            run_len = $urandom_range(1, 5);
            for (int k = 0; k < run_len; k++) begin
              offer_item(pick_byte(g), 1'b0, (r == runs - 1 && k == run_len - 1), gapless);
              sent++;
            end
          end
        end
      endcase
    end
  endtask

  // Result side: segments of random stall density, plus one long hold-off on request
  initial begin : result_drain
    int seg;
    int pct;
    bit hold_done;
    hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      case ($urandom_range(0, 4))
        0, 1:    pct = 100;
        2:       pct = 75;
        3:       pct = 50;
        default: pct = 25;
      endcase
      seg = $urandom_range(1, 30);
      repeat (seg) begin
        if (hold_off_req && !hold_done) begin
          out_ch.ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
          hold_done = 1'b1;
        end
        out_ch.ready <= ($urandom_range(0, 99) < pct);
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    rst_n            <= 1'b0;
    hold_off_req     <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.char_byte  <= 8'h00;
    in_ch.line_empty <= 1'b0;
    in_ch.line_end   <= 1'b0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= twlh_pkg::CFG_FOLD_CASE;
    cfg_ch.data      <= 1'b0;
    burst_left = 0;
    items_sent = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: class edges, sign-extended bytes, junk on empty lines
    write_reg(twlh_pkg::CFG_FOLD_CASE, 1'b0);
    write_reg(twlh_pkg::CFG_SKIP_SPACES, 1'b0);
    offer_item(" ", 1'b0, 1'b0, 1'b0);
    offer_item(8'h09, 1'b0, 1'b0, 1'b0);
    offer_item("A", 1'b0, 1'b0, 1'b0);
    offer_item("z", 1'b0, 1'b0, 1'b0);
    offer_item("0", 1'b0, 1'b0, 1'b0);
    offer_item("9", 1'b0, 1'b0, 1'b0);
    offer_item("_", 1'b0, 1'b0, 1'b0);
    offer_item("Z", 1'b0, 1'b0, 1'b0);
    offer_item("@", 1'b0, 1'b0, 1'b0);
    offer_item(8'h80, 1'b0, 1'b0, 1'b0);
    offer_item(8'hFF, 1'b0, 1'b0, 1'b0);
    offer_item(8'h00, 1'b0, 1'b1, 1'b0);
    offer_item(8'hFF, 1'b1, 1'b1, 1'b0);
    // Unterminated line closed by an empty-line transaction
    offer_item("Q", 1'b0, 1'b0, 1'b0);
    offer_item("[", 1'b0, 1'b0, 1'b0);
    offer_item(8'h00, 1'b1, 1'b0, 1'b0);
    offer_item("x", 1'b0, 1'b1, 1'b0);
    drain_results();

    // Directed: folded case and dropped spaces
    write_reg(twlh_pkg::CFG_FOLD_CASE, 1'b1);
    write_reg(twlh_pkg::CFG_SKIP_SPACES, 1'b1);
    offer_item(" ", 1'b0, 1'b0, 1'b0);
    offer_item("A", 1'b0, 1'b0, 1'b0);
    offer_item("Z", 1'b0, 1'b0, 1'b0);
    offer_item(8'h60, 1'b0, 1'b0, 1'b0);
    offer_item("@", 1'b0, 1'b0, 1'b0);
    offer_item(" ", 1'b0, 1'b0, 1'b0);
    offer_item(8'h09, 1'b0, 1'b1, 1'b0);
    drain_results();

    // Random phases; lines may stay open across a register change
    for (int p = 0; p < 5; p++) begin
      write_reg(twlh_pkg::CFG_FOLD_CASE, FOLD_PLAN[p]);
      write_reg(twlh_pkg::CFG_SKIP_SPACES, SKIP_PLAN[p]);
      if (p == 2) hold_off_req <= 1'b1;
      random_text(PHASE_ITEMS, p == 2);
      drain_results();
    end
    repeat (20) @(posedge clk);

    $display("Summary: %0d input transactions, %0d records checked over seven register settings",
             items_sent, records_checked);
    $display("Summary: class edges, sign-extended bytes, empty-line closes and a long hold-off");
    if (fail_count == 0 && pending_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #8ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
